// ===== rtl/krgc_pkg.sv =====
package krgc_pkg;

  localparam int CHUNK_BYTES = 8;
  localparam int LOCI        = CHUNK_BYTES * 8;
  localparam int CNT_W       = $clog2(LOCI + 1);
  localparam int ACC_W       = 32;
  localparam int NB_W        = 4;

  // record queue between classifier and accumulator
  localparam int REC_DEPTH   = 4;
  localparam int REC_PTR_W   = $clog2(REC_DEPTH);
  localparam int REC_CNT_W   = $clog2(REC_DEPTH + 1);

  // result queue at the output
  localparam int RES_DEPTH   = 2;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0] opp;
    logic [CNT_W-1:0] valid;
    logic [CNT_W-1:0] het;
    logic [CNT_W-1:0] hom_i;
    logic [CNT_W-1:0] hom_j;
    logic             last;
  } rec_t;

  typedef struct packed {
    logic [ACC_W-1:0] opp;
    logic [ACC_W-1:0] valid;
    logic [ACC_W-1:0] sumsq;
    logic [ACC_W-1:0] hom_i;
    logic [ACC_W-1:0] hom_j;
  } res_t;

  function automatic logic [CNT_W-1:0] popcnt(input logic [LOCI-1:0] x);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < LOCI; k++) begin
      n = n + CNT_W'(x[k]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/king_robust_genotype_counter.sv =====
// Pairwise genotype comparison counter. Each transaction pushed in carries
// 64 loci of two bit planes for samples i and j (a=0,b=1 is missing) plus
// the number of low bytes that hold real loci (values above 8 act as 8).
// Five counts (opposite homozygotes, loci valid in both, het-differing,
// and first-plane-only homozygotes of i and of j) build up modulo 2^32.
// The transaction flagged last_chunk adds its own counts, queues one result
// with sum_squares = het_diff + 4*opposite, and clears the counts for the
// next pair. Rate: one input transaction per clock while full is low.
// The front classifies and popcounts all 64 loci combinationally into
// a 4-deep record queue; the back drains one record per clock into the
// accumulators unless a last record waits for a free result slot, and
// results wait in a 2-deep output queue, so input keeps flowing while a
// result is not yet popped. A result is queued as its last record drains
// and can then be popped. full rises only when the record queue fills,
// i.e. when results back up and further last records cannot drain.
module king_robust_genotype_counter
  import krgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,

  // input queue side
  input  logic             push,
  output logic             full,
  input  logic [LOCI-1:0]  plane_a_i,
  input  logic [LOCI-1:0]  plane_b_i,
  input  logic [LOCI-1:0]  plane_a_j,
  input  logic [LOCI-1:0]  plane_b_j,
  input  logic [NB_W-1:0]  bytes_valid,
  input  logic             last_chunk,

  // result queue side
  output logic             empty,
  input  logic             pop,
  output logic [ACC_W-1:0] opposite_hom_count,
  output logic [ACC_W-1:0] valid_loci,
  output logic [ACC_W-1:0] sum_squares,
  output logic [ACC_W-1:0] hom_first_i,
  output logic [ACC_W-1:0] hom_first_j
);

  rec_t front_rec;
  rec_t q_rec;
  logic q_valid;
  logic q_pop;
  res_t res;

  // classify + popcount
  krgc_front u_front (
    .plane_a_i   (plane_a_i),
    .plane_b_i   (plane_b_i),
    .plane_a_j   (plane_a_j),
    .plane_b_j   (plane_b_j),
    .bytes_valid (bytes_valid),
    .last_chunk  (last_chunk),
    .rec         (front_rec)
  );

  // decoupling queue; its full flag is the input full
  krgc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (front_rec),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_rec),
    .rd_valid (q_valid)
  );

  // accumulate, emit on last, hold results
  krgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_valid),
    .rec       (q_rec),
    .rec_pop   (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign opposite_hom_count = res.opp;
  assign valid_loci         = res.valid;
  assign sum_squares        = res.sumsq;
  assign hom_first_i        = res.hom_i;
  assign hom_first_j        = res.hom_j;

endmodule

// ===== rtl/krgc_front.sv =====
module krgc_front
  import krgc_pkg::*;
(
  input  logic [LOCI-1:0] plane_a_i,
  input  logic [LOCI-1:0] plane_b_i,
  input  logic [LOCI-1:0] plane_a_j,
  input  logic [LOCI-1:0] plane_b_j,
  input  logic [NB_W-1:0] bytes_valid,
  input  logic            last_chunk,
  output rec_t            rec
);

  logic [NB_W-1:0] nb_sat;
  logic [LOCI-1:0] lanes;
  logic [LOCI-1:0] e1;
  logic [LOCI-1:0] e2;
  logic [LOCI-1:0] valid;

  // clamp byte count, then open one 8-bit lane per valid byte
  assign nb_sat = (bytes_valid > NB_W'(CHUNK_BYTES)) ? NB_W'(CHUNK_BYTES) : bytes_valid;

  always_comb begin
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      lanes[k*8 +: 8] = (nb_sat > NB_W'(k)) ? 8'hFF : 8'h00;
    end
  end

  assign e1    = plane_a_i ^ plane_a_j;
  assign e2    = plane_b_i ^ plane_b_j;
  // missing is a=0, b=1
  assign valid = (plane_a_i | ~plane_b_i) & (plane_a_j | ~plane_b_j) & lanes;

  assign rec.opp   = popcnt(e1 & e2 & valid);
  assign rec.valid = popcnt(valid);
  assign rec.het   = popcnt((e1 ^ e2) & valid);
  assign rec.hom_i = popcnt(plane_a_i & ~plane_b_i & valid);
  assign rec.hom_j = popcnt(plane_a_j & ~plane_b_j & valid);
  assign rec.last  = last_chunk;

endmodule

// ===== rtl/krgc_fifo.sv =====
module krgc_fifo
  import krgc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  rec_t wr_data,
  output logic full,
  input  logic rd_en,
  output rec_t rd_data,
  output logic rd_valid
);

  rec_t                 mem [REC_DEPTH];
  logic [REC_PTR_W-1:0] wr_ptr;
  logic [REC_PTR_W-1:0] rd_ptr;
  logic [REC_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full     = (count == REC_CNT_W'(REC_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + REC_CNT_W'(do_wr) - REC_CNT_W'(do_rd);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= REC_CNT_W'(REC_DEPTH))
    else $error("record queue over depth");

  a_wr_fills: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> rd_valid)
    else $error("record queue empty after write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    !full && rd_valid |-> wr_ptr != rd_ptr)
    else $error("record queue pointers inconsistent with count");

endmodule

// ===== rtl/krgc_back.sv =====
module krgc_back
  import krgc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic rec_valid,
  input  rec_t rec,
  output logic rec_pop,
  input  logic res_pop,
  output logic res_empty,
  output res_t res
);

  logic [ACC_W-1:0] acc_opposite;
  logic [ACC_W-1:0] acc_valid;
  logic [ACC_W-1:0] acc_het_diff;
  logic [ACC_W-1:0] acc_hom_i;
  logic [ACC_W-1:0] acc_hom_j;

  logic [ACC_W-1:0] opp_next;
  logic [ACC_W-1:0] valid_next;
  logic [ACC_W-1:0] het_next;
  logic [ACC_W-1:0] hom_i_next;
  logic [ACC_W-1:0] hom_j_next;

  res_t                 res_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_ptr;
  logic [RES_PTR_W-1:0] res_rd_ptr;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_full;
  logic                 out_pop;
  logic                 res_wr;
  res_t                 res_new;

  assign res_full  = (res_count == RES_CNT_W'(RES_DEPTH));
  assign res_empty = (res_count == '0);
  assign res       = res_mem[res_rd_ptr];
  assign out_pop   = res_pop && !res_empty;

  // a last record needs a free result slot; a slot freed this cycle counts
  assign rec_pop = rec_valid && (!rec.last || !res_full || out_pop);
  assign res_wr  = rec_pop && rec.last;

  assign opp_next   = acc_opposite + ACC_W'(rec.opp);
  assign valid_next = acc_valid    + ACC_W'(rec.valid);
  assign het_next   = acc_het_diff + ACC_W'(rec.het);
  assign hom_i_next = acc_hom_i    + ACC_W'(rec.hom_i);
  assign hom_j_next = acc_hom_j    + ACC_W'(rec.hom_j);

  assign res_new.opp   = opp_next;
  assign res_new.valid = valid_next;
  assign res_new.sumsq = het_next + {opp_next[ACC_W-3:0], 2'b00};
  assign res_new.hom_i = hom_i_next;
  assign res_new.hom_j = hom_j_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_opposite <= '0;
      acc_valid    <= '0;
      acc_het_diff <= '0;
      acc_hom_i    <= '0;
      acc_hom_j    <= '0;
    end else if (rec_pop) begin
      if (rec.last) begin
        acc_opposite <= '0;
        acc_valid    <= '0;
        acc_het_diff <= '0;
        acc_hom_i    <= '0;
        acc_hom_j    <= '0;
      end else begin
        acc_opposite <= opp_next;
        acc_valid    <= valid_next;
        acc_het_diff <= het_next;
        acc_hom_i    <= hom_i_next;
        acc_hom_j    <= hom_j_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem[res_wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (res_wr) begin
        res_wr_ptr <= res_wr_ptr + 1'b1;
      end
      if (out_pop) begin
        res_rd_ptr <= res_rd_ptr + 1'b1;
      end
      res_count <= res_count + RES_CNT_W'(res_wr) - RES_CNT_W'(out_pop);
    end
  end

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue over depth");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    res_wr |=> !res_empty)
    else $error("last record produced no result");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    res_wr |=> acc_valid == '0 && acc_opposite == '0 && acc_het_diff == '0)
    else $error("counts not cleared after last record");

  a_mid_no_result: assert property (@(posedge clk) disable iff (rst)
    rec_pop && !rec.last && !out_pop |=> $stable(res_count))
    else $error("result queue moved on a non-last record");

endmodule
